### src/assert_macros.svh
// assertion macros used by the node's top-level rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is low
`define ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication, disabled while reset is low
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

### src/ewm_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ewm_pkg
// types, field widths and codes shared by the echo-wave node modules
// ---------------------------------------------------------------------------
package ewm_pkg;

    localparam int ID_W   = 8;
    localparam int TAG_W  = 2;
    localparam int VAL_W  = 32;
    localparam int CNT_W  = 4;
    localparam int IDS_W  = 64;
    localparam int CIDX_W = 2;

    localparam logic [TAG_W-1:0] TAG_DOWN = 2'd0;
    localparam logic [TAG_W-1:0] TAG_CALC = 2'd1;
    localparam logic [TAG_W-1:0] TAG_UP   = 2'd2;
    localparam logic [TAG_W-1:0] TAG_END  = 2'd3;

    typedef enum logic [CIDX_W-1:0] {
        CFG_IS_INITIATOR   = 2'd0,
        CFG_NEIGHBOR_COUNT = 2'd1,
        CFG_NEIGHBOR_IDS   = 2'd2,
        CFG_LOCAL_VALUE    = 2'd3
    } t_cfg_idx;

    typedef enum logic [1:0] {
        PH_IDLE     = 2'd0,
        PH_WAVE     = 2'd1,
        PH_REPORTED = 2'd2,
        PH_DONE     = 2'd3
    } t_phase;

    typedef enum logic {
        ST_IDLE = 1'b0,
        ST_EMIT = 1'b1
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic accept;
        logic load;
    } t_ctrl;

    // datapath to controller
    typedef struct packed {
        logic slot_free;
        logic last;
    } t_stat;

endpackage

### src/echo_wave_min_node.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// echo_wave_min_node
// one node of an echo-wave minimum reduction
// ---------------------------------------------------------------------------
// input channel (i_valid / o_ready) takes a start command or a received
// message; output channel (o_valid / i_ready) returns one to eight result
// items per input item, the final one flagged by o_last. an item that sends
// nothing still returns one result with o_send_valid low.
// configuration is a plain write port (i_cfg_we, i_cfg_index, i_cfg_data),
// to be written only while the node is idle; the node does not enforce this.
// timing: an accepted item moves the sequencer to its emit state, which loads
// its results into the output register, one result per cycle while the
// receiver is ready; the next item is taken in the cycle after its last
// result is loaded. the single output register, paced by the emit
// sequencer, sets this rate.
// when the receiver stalls, the emitter holds until the output register is
// taken; the final result may wait there while the next item is accepted.
// reset (synchronous, active low) returns the configuration to its defaults,
// the node to the idle phase with empty masks, and drops o_valid.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module echo_wave_min_node #(
    parameter int MAX_NEIGHBORS = 8,
    parameter int NODE_ID_BITS  = 8
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [ewm_pkg::CIDX_W-1:0]        i_cfg_index,
    input  logic [ewm_pkg::IDS_W-1:0]         i_cfg_data,
    input  logic                              i_valid,
    output logic                              o_ready,
    input  logic                              i_command,
    input  logic [ewm_pkg::ID_W-1:0]          i_source_node,
    input  logic [ewm_pkg::TAG_W-1:0]         i_msg_tag,
    input  logic signed [ewm_pkg::VAL_W-1:0]  i_msg_value,
    output logic                              o_valid,
    input  logic                              i_ready,
    output logic                              o_send_valid,
    output logic [ewm_pkg::ID_W-1:0]          o_dest_node,
    output logic [ewm_pkg::TAG_W-1:0]         o_out_tag,
    output logic signed [ewm_pkg::VAL_W-1:0]  o_out_value,
    output logic                              o_last,
    output logic                              o_finished,
    output logic                              o_status
);
    import ewm_pkg::*;

    t_ctrl w_ctrl;
    t_stat w_stat;

    ewm_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_stat  (w_stat),
        .o_ctrl  (w_ctrl)
    );

    ewm_datapath #(
        .MAX_NEIGHBORS (MAX_NEIGHBORS),
        .NODE_ID_BITS  (NODE_ID_BITS)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_command     (i_command),
        .i_source_node (i_source_node),
        .i_msg_tag     (i_msg_tag),
        .i_msg_value   (i_msg_value),
        .i_ctrl        (w_ctrl),
        .o_stat        (w_stat),
        .i_ready       (i_ready),
        .o_valid       (o_valid),
        .o_send_valid  (o_send_valid),
        .o_dest_node   (o_dest_node),
        .o_out_tag     (o_out_tag),
        .o_out_value   (o_out_value),
        .o_last        (o_last),
        .o_finished    (o_finished),
        .o_status      (o_status)
    );

    // no item is taken while results of the previous one are still emitted
    `ASSERT_SAME(a_accept_not_load, i_clk, i_rst_n, w_ctrl.accept, !w_ctrl.load)
    // after an accept the input side is busy until its results are out
    `ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, w_ctrl.accept, !o_ready)
    // loading the final result frees the input side
    `ASSERT_NEXT(a_ready_after_last, i_clk, i_rst_n, w_ctrl.load && w_stat.last,
                 o_ready && o_valid && o_last)
    // a loaded result always lands in the output register
    `ASSERT_NEXT(a_load_shows, i_clk, i_rst_n, w_ctrl.load, o_valid)

endmodule

### src/ewm_ctrl.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ewm_ctrl
// sequencer: takes one item, then steps the result emitter until the last one
// ---------------------------------------------------------------------------
module ewm_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  ewm_pkg::t_stat i_stat,
    output ewm_pkg::t_ctrl o_ctrl
);
    import ewm_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state       = r_state;
        o_ready       = 1'b0;
        o_ctrl.accept = 1'b0;
        o_ctrl.load   = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    o_ctrl.accept = 1'b1;
                    n_state       = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (i_stat.slot_free) begin
                    o_ctrl.load = 1'b1;
                    if (i_stat.last) begin
                        n_state = ST_IDLE;
                    end
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

endmodule

### src/ewm_datapath.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ewm_datapath
// configuration, wave state, per-item update and the result emitter
// ---------------------------------------------------------------------------
module ewm_datapath #(
    parameter int MAX_NEIGHBORS = 8,
    parameter int NODE_ID_BITS  = 8
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [ewm_pkg::CIDX_W-1:0]        i_cfg_index,
    input  logic [ewm_pkg::IDS_W-1:0]         i_cfg_data,
    input  logic                              i_command,
    input  logic [ewm_pkg::ID_W-1:0]          i_source_node,
    input  logic [ewm_pkg::TAG_W-1:0]         i_msg_tag,
    input  logic signed [ewm_pkg::VAL_W-1:0]  i_msg_value,
    input  ewm_pkg::t_ctrl                    i_ctrl,
    output ewm_pkg::t_stat                    o_stat,
    input  logic                              i_ready,
    output logic                              o_valid,
    output logic                              o_send_valid,
    output logic [ewm_pkg::ID_W-1:0]          o_dest_node,
    output logic [ewm_pkg::TAG_W-1:0]         o_out_tag,
    output logic signed [ewm_pkg::VAL_W-1:0]  o_out_value,
    output logic                              o_last,
    output logic                              o_finished,
    output logic                              o_status
);
    import ewm_pkg::*;

    localparam int M = MAX_NEIGHBORS;

    // configuration
    logic                    r_is_init;
    logic [CNT_W-1:0]        r_nb_count;
    logic [IDS_W-1:0]        r_nb_ids;
    logic signed [VAL_W-1:0] r_local;

    // wave state
    t_phase                  r_phase,  n_phase;
    logic [M-1:0]            r_recv,   n_recv;
    logic [M-1:0]            r_child,  n_child;
    logic                    r_pv,     n_pv;
    logic [NODE_ID_BITS-1:0] r_pid,    n_pid;
    logic signed [VAL_W-1:0] r_min,    n_min;

    // pending results of the current item
    logic [M-1:0]            r_mask,   n_mask;
    logic [TAG_W-1:0]        r_tag,    n_tag;
    logic                    r_up,     n_up;
    logic                    r_status, n_status;

    // output register
    logic                    r_o_valid;
    logic                    r_o_send;
    logic [ID_W-1:0]         r_o_dest;
    logic [TAG_W-1:0]        r_o_tag;
    logic signed [VAL_W-1:0] r_o_value;
    logic                    r_o_last;
    logic                    r_o_fin;
    logic                    r_o_status;

    logic [CNT_W-1:0]        w_cnt;
    logic [M-1:0]            w_all;
    logic [M-1:0]            w_match;
    logic [M-1:0]            w_nparent;
    logic [NODE_ID_BITS-1:0] w_id [M];
    logic [NODE_ID_BITS-1:0] w_src;
    logic                    w_first;
    logic [M-1:0]            w_recv_b;
    logic [M-1:0]            w_child_b;
    logic                    w_pv_b;
    logic [NODE_ID_BITS-1:0] w_pid_b;
    logic signed [VAL_W-1:0] w_min_b;
    logic [M-1:0]            w_low;
    logic [NODE_ID_BITS-1:0] w_sel_id;
    logic                    w_e_send;
    logic [ID_W-1:0]         w_e_dest;
    logic [TAG_W-1:0]        w_e_tag;
    logic                    w_e_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_is_init  <= 1'b0;
            r_nb_count <= CNT_W'(1);
            r_nb_ids   <= '0;
            r_local    <= '0;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_IS_INITIATOR:   r_is_init  <= i_cfg_data[0];
                CFG_NEIGHBOR_COUNT: r_nb_count <= i_cfg_data[CNT_W-1:0];
                CFG_NEIGHBOR_IDS:   r_nb_ids   <= i_cfg_data;
                CFG_LOCAL_VALUE:    r_local    <= signed'(i_cfg_data[VAL_W-1:0]);
                default: ;
            endcase
        end
    end

    assign w_cnt = (r_nb_count > CNT_W'(M)) ? CNT_W'(M) : r_nb_count;
    assign w_src = i_source_node[NODE_ID_BITS-1:0];

    assign w_first   = (r_phase == PH_IDLE);
    assign w_recv_b  = w_first ? '0 : r_recv;
    assign w_child_b = w_first ? '0 : r_child;
    assign w_pv_b    = w_first ? 1'b1 : r_pv;
    assign w_pid_b   = w_first ? w_src : r_pid;
    assign w_min_b   = w_first ? r_local : r_min;

    always_comb begin
        for (int i = 0; i < M; i++) begin
            w_id[i]      = r_nb_ids[i*ID_W +: NODE_ID_BITS];
            w_all[i]     = (CNT_W'(i) < w_cnt);
            w_match[i]   = w_all[i] && (w_id[i] == w_src);
            w_nparent[i] = w_all[i] && (w_id[i] != w_pid_b);
        end
    end

    // state update of one accepted item
    always_comb begin
        n_phase  = r_phase;
        n_recv   = r_recv;
        n_child  = r_child;
        n_pv     = r_pv;
        n_pid    = r_pid;
        n_min    = r_min;
        n_mask   = '0;
        n_tag    = TAG_DOWN;
        n_up     = 1'b0;
        n_status = 1'b0;
        if (!i_command) begin
            if (r_is_init && (r_phase == PH_IDLE)) begin
                n_min   = r_local;
                n_recv  = '0;
                n_child = '0;
                n_pv    = 1'b0;
                n_pid   = '0;
                n_phase = (w_cnt == '0) ? PH_DONE : PH_WAVE;
                n_mask  = w_all;
                n_tag   = TAG_DOWN;
            end else begin
                n_status = 1'b1;
            end
        end else if ((r_phase == PH_IDLE) && r_is_init) begin
            n_status = 1'b1;
        end else if ((r_phase == PH_IDLE) || (r_phase == PH_WAVE)) begin
            n_recv  = w_recv_b | w_match;
            n_child = w_child_b | ((i_msg_tag == TAG_UP) ? w_match : '0);
            n_pv    = w_pv_b;
            n_pid   = w_pid_b;
            n_min   = (i_msg_value < w_min_b) ? i_msg_value : w_min_b;
            n_phase = PH_WAVE;
            if (w_first) begin
                n_mask = w_nparent;
                n_tag  = TAG_CALC;
            end
            // a completing first message leaves no calc to send, so the masks never clash
            if ((n_recv & w_all) == w_all) begin
                if (w_pv_b) begin
                    n_up    = 1'b1;
                    n_phase = PH_REPORTED;
                end else begin
                    n_mask  = n_child & w_all;
                    n_tag   = TAG_END;
                    n_phase = PH_DONE;
                end
            end
        end else if ((r_phase == PH_REPORTED) && (i_msg_tag == TAG_END)) begin
            n_min   = (i_msg_value < r_min) ? i_msg_value : r_min;
            n_mask  = r_child & w_all;
            n_tag   = TAG_END;
            n_phase = PH_DONE;
        end else begin
            n_status = 1'b1;
        end
    end

    // lowest pending neighbor goes out first
    assign w_low = r_mask & (~r_mask + M'(1));

    always_comb begin
        w_sel_id = '0;
        for (int i = 0; i < M; i++) begin
            w_sel_id = w_sel_id | ({NODE_ID_BITS{w_low[i]}} & w_id[i]);
        end
    end

    always_comb begin
        if (r_mask != '0) begin
            w_e_send = 1'b1;
            w_e_dest = ID_W'(w_sel_id);
            w_e_tag  = r_tag;
            w_e_last = ((r_mask & ~w_low) == '0) && !r_up;
        end else if (r_up) begin
            w_e_send = 1'b1;
            w_e_dest = ID_W'(r_pid);
            w_e_tag  = TAG_UP;
            w_e_last = 1'b1;
        end else begin
            // nothing to send: one empty result
            w_e_send = 1'b0;
            w_e_dest = '0;
            w_e_tag  = TAG_DOWN;
            w_e_last = 1'b1;
        end
    end

    assign o_stat.slot_free = !r_o_valid || i_ready;
    assign o_stat.last      = w_e_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_recv  <= '0;
            r_child <= '0;
            r_pv    <= 1'b0;
            r_pid   <= '0;
            r_min   <= '0;
            r_mask  <= '0;
            r_up    <= 1'b0;
        end else if (i_ctrl.accept) begin
            r_phase <= n_phase;
            r_recv  <= n_recv;
            r_child <= n_child;
            r_pv    <= n_pv;
            r_pid   <= n_pid;
            r_min   <= n_min;
            r_mask  <= n_mask;
            r_up    <= n_up;
        end else if (i_ctrl.load) begin
            if (r_mask != '0) begin
                r_mask <= r_mask & ~w_low;
            end else begin
                r_up <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.accept) begin
            r_tag    <= n_tag;
            r_status <= n_status;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (i_ctrl.load) begin
            r_o_valid <= 1'b1;
        end else if (i_ready) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.load) begin
            r_o_send   <= w_e_send;
            r_o_dest   <= w_e_dest;
            r_o_tag    <= w_e_tag;
            r_o_value  <= r_min;
            r_o_last   <= w_e_last;
            r_o_fin    <= (r_phase == PH_DONE);
            r_o_status <= r_status;
        end
    end

    assign o_valid      = r_o_valid;
    assign o_send_valid = r_o_send;
    assign o_dest_node  = r_o_dest;
    assign o_out_tag    = r_o_tag;
    assign o_out_value  = r_o_value;
    assign o_last       = r_o_last;
    assign o_finished   = r_o_fin;
    assign o_status     = r_o_status;

endmodule

### tb/echo_wave_min_node_test.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// echo_wave_min_node_test
// self-checking bench for one node of the echo-wave minimum reduction
// ---------------------------------------------------------------------------
// a scoreboard class mirrors the node (phase, report and child masks, parent,
// running minimum) and queues the result items each accepted input item must
// produce. the role (initiator or not) is picked at random per run since a
// node finishes only one wave between resets. the run does a few directed
// idle-phase checks, starts the wave, keeps it open with random reports,
// duplicates, strangers and stray start commands while the configuration is
// changed between bursts, then closes the wave either by reporting the
// remaining neighbors or by dropping the neighbor count to zero, and finally
// pokes the finished node. both handshakes idle at random and the receiver
// holds off once for a long stretch.
// ---------------------------------------------------------------------------

localparam logic CMD_START   = 1'b0;
localparam logic CMD_MESSAGE = 1'b1;

typedef struct packed {
    logic        send_valid;
    logic [7:0]  dest;
    logic [1:0]  tag;
    logic [31:0] value;
    logic        last;
    logic        finished;
    logic        status;
} wave_result;

class min_wave_scoreboard;
    // register mirror, at reset values
    logic               is_root    = 1'b0;
    logic [3:0]         nb_count   = 4'd1;
    logic [63:0]        nb_ids     = '0;
    logic signed [31:0] own_value  = '0;
    // node state
    ewm_pkg::t_phase    phase      = ewm_pkg::PH_IDLE;
    logic [7:0]         heard      = '0;
    logic [7:0]         children   = '0;
    logic               has_parent = 1'b0;
    logic [7:0]         parent_id  = '0;
    logic signed [31:0] run_min    = '0;
    wave_result         due_results[$];
    wave_result         burst[$];
    int                 errors     = 0;

    function void set_reg(ewm_pkg::t_cfg_idx idx, logic [63:0] data);
        case (idx)
            ewm_pkg::CFG_IS_INITIATOR:   is_root   = data[0];
            ewm_pkg::CFG_NEIGHBOR_COUNT: nb_count  = data[3:0];
            ewm_pkg::CFG_NEIGHBOR_IDS:   nb_ids    = data;
            ewm_pkg::CFG_LOCAL_VALUE:    own_value = data[31:0];
            default: ;
        endcase
    endfunction

    function int live_neighbors();
        return (nb_count > 4'd8) ? 8 : int'(nb_count);
    endfunction

    function logic [7:0] neighbor_id(int k);
        return nb_ids[8*k +: 8];
    endfunction

    function logic [7:0] full_mask();
        return 8'((16'd1 << live_neighbors()) - 16'd1);
    endfunction

    // base with every table slot holding src marked
    function logic [7:0] slots_of(logic [7:0] src, logic [7:0] base);
        logic [7:0] m;
        m = base;
        for (int k = 0; k < live_neighbors(); k++)
            if (neighbor_id(k) == src) m[k] = 1'b1;
        return m;
    endfunction

    function bit is_neighbor(logic [7:0] src);
        return slots_of(src, 8'd0) != 8'd0;
    endfunction

    function bit is_heard(logic [7:0] src);
        return (slots_of(src, 8'd0) & heard) != 8'd0;
    endfunction

    function bit would_complete(logic [7:0] src);
        return (slots_of(src, heard) & full_mask()) == full_mask();
    endfunction

    function void queue_send(logic [7:0] dest, logic [1:0] tag);
        wave_result r;
        r = '0;
        r.send_valid = 1'b1;
        r.dest = dest;
        r.tag = tag;
        if (burst.size() < 8) burst.push_back(r);
    endfunction

    function void send_end_to_children();
        for (int k = 0; k < live_neighbors(); k++)
            if (children[k]) queue_send(neighbor_id(k), ewm_pkg::TAG_END);
    endfunction

    // predicts the result items of one accepted item, returns 1 if ignored
    function bit take_item(logic cmd, logic [7:0] src, logic [1:0] tag,
                           logic signed [31:0] val);
        bit ignored;
        bit first;
        int n;
        wave_result r;
        ignored = 1'b0;
        n = live_neighbors();
        burst.delete();
        if (cmd == CMD_START) begin
            if (is_root && phase == ewm_pkg::PH_IDLE) begin
                run_min = own_value;
                heard = '0;
                children = '0;
                has_parent = 1'b0;
                parent_id = '0;
                phase = ewm_pkg::PH_WAVE;
                for (int k = 0; k < n; k++) queue_send(neighbor_id(k), ewm_pkg::TAG_DOWN);
                if (n == 0) phase = ewm_pkg::PH_DONE;
            end else begin
                ignored = 1'b1;
            end
        end else if (phase == ewm_pkg::PH_IDLE && is_root) begin
            ignored = 1'b1;
        end else if (phase == ewm_pkg::PH_IDLE || phase == ewm_pkg::PH_WAVE) begin
            first = (phase == ewm_pkg::PH_IDLE);
            if (first) begin
                run_min = own_value;
                heard = '0;
                children = '0;
                has_parent = 1'b1;
                parent_id = src;
                phase = ewm_pkg::PH_WAVE;
            end
            heard = slots_of(src, heard);
            if (val < run_min) run_min = val;
            if (first)
                for (int k = 0; k < n; k++)
                    if (neighbor_id(k) != parent_id) queue_send(neighbor_id(k), ewm_pkg::TAG_CALC);
            if (tag == ewm_pkg::TAG_UP) children = slots_of(src, children);
            if ((heard & full_mask()) == full_mask()) begin
                if (has_parent) begin
                    queue_send(parent_id, ewm_pkg::TAG_UP);
                    phase = ewm_pkg::PH_REPORTED;
                end else begin
                    send_end_to_children();
                    phase = ewm_pkg::PH_DONE;
                end
            end
        end else if (phase == ewm_pkg::PH_REPORTED && tag == ewm_pkg::TAG_END) begin
            if (val < run_min) run_min = val;
            send_end_to_children();
            phase = ewm_pkg::PH_DONE;
        end else begin
            ignored = 1'b1;
        end

        // nothing to send still gives one quiet result
        if (burst.size() == 0) begin
            r = '0;
            burst.push_back(r);
        end
        foreach (burst[i]) begin
            r = burst[i];
            r.value = run_min;
            r.last = (i == burst.size() - 1);
            r.finished = (phase == ewm_pkg::PH_DONE);
            r.status = ignored;
            due_results.push_back(r);
        end
        return ignored;
    endfunction

    function void match_result(wave_result got);
        wave_result want;
        if (due_results.size() == 0) begin
            errors++;
            if (errors <= 10)
                $display("unexpected result item: send=%0d dest=%0h tag=%0d value=%0d",
                         got.send_valid, got.dest, got.tag, $signed(got.value));
            return;
        end
        want = due_results.pop_front();
        if (got.send_valid !== want.send_valid || got.dest !== want.dest ||
            got.tag !== want.tag || got.value !== want.value || got.last !== want.last ||
            got.finished !== want.finished || got.status !== want.status) begin
            errors++;
            if (errors <= 10) begin
                $display("result mismatch at %0t", $realtime);
                $display("  want send=%0d dest=%0h tag=%0d value=%0d last=%0d fin=%0d st=%0d",
                         want.send_valid, want.dest, want.tag, $signed(want.value),
                         want.last, want.finished, want.status);
                $display("  got  send=%0d dest=%0h tag=%0d value=%0d last=%0d fin=%0d st=%0d",
                         got.send_valid, got.dest, got.tag, $signed(got.value),
                         got.last, got.finished, got.status);
            end
        end
    endfunction

    function int pending();
        return due_results.size();
    endfunction
endclass

module echo_wave_min_node_test;
    import ewm_pkg::*;

    logic                      i_clk = 1'b0;
    logic                      i_rst_n;
    logic                      i_cfg_we;
    logic [CIDX_W-1:0]         i_cfg_index;
    logic [IDS_W-1:0]          i_cfg_data;
    logic                      i_valid;
    logic                      o_ready;
    logic                      i_command;
    logic [ID_W-1:0]           i_source_node;
    logic [TAG_W-1:0]          i_msg_tag;
    logic signed [VAL_W-1:0]   i_msg_value;
    logic                      o_valid;
    logic                      i_ready = 1'b0;
    logic                      o_send_valid;
    logic [ID_W-1:0]           o_dest_node;
    logic [TAG_W-1:0]          o_out_tag;
    logic signed [VAL_W-1:0]   o_out_value;
    logic                      o_last;
    logic                      o_finished;
    logic                      o_status;

    min_wave_scoreboard sb = new;
    bit steady = 1'b0;
    bit hold_req = 1'b0;
    bit last_ignored;
    logic [1:0] tag_list [4] = '{TAG_DOWN, TAG_CALC, TAG_UP, TAG_END};

    echo_wave_min_node u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_command     (i_command),
        .i_source_node (i_source_node),
        .i_msg_tag     (i_msg_tag),
        .i_msg_value   (i_msg_value),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_send_valid  (o_send_valid),
        .o_dest_node   (o_dest_node),
        .o_out_tag     (o_out_tag),
        .o_out_value   (o_out_value),
        .o_last        (o_last),
        .o_finished    (o_finished),
        .o_status      (o_status)
    );

    always begin
        i_clk = 1'b1;
        #10;
        i_clk = 1'b0;
        #10;
    end

    initial begin
        #5000000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    function automatic logic signed [31:0] rand_value();
        case ($urandom_range(0, 9))
            0: return {1'b1, 31'b0};
            1: return {1'b0, {31{1'b1}}};
            2: return '0;
            3: return '1;
            4, 5: return $signed($urandom_range(0, 2000)) - 32'sd1000;
            default: return $urandom;
        endcase
    endfunction

    // kind 0: unreported neighbor, 1: any neighbor, 2: stranger;
    // unless allow_last, never the sender that would close the wave
    function automatic logic [7:0] pick_source(int kind, bit allow_last);
        logic [7:0] cand;
        int n;
        n = sb.live_neighbors();
        for (int tries = 0; tries < 32; tries++) begin
            if (kind != 2 && n > 0) cand = sb.neighbor_id($urandom_range(0, n - 1));
            else cand = 8'($urandom_range(0, 255));
            if (kind == 0 && sb.is_heard(cand)) continue;
            if (kind == 2 && sb.is_neighbor(cand)) continue;
            if (!allow_last && sb.would_complete(cand)) continue;
            return cand;
        end
        do cand = 8'($urandom_range(0, 255));
        while (sb.is_neighbor(cand) || (!allow_last && sb.would_complete(cand)));
        return cand;
    endfunction

    // eight distinct ids, slot 0 at 00 and slot 7 at ff
    function automatic logic [63:0] make_ids();
        logic [63:0] ids;
        logic [7:0] b;
        bit clash;
        ids = '0;
        ids[63:56] = 8'hff;
        for (int k = 1; k < 7; k++) begin
            do begin
                b = 8'($urandom_range(1, 254));
                clash = 1'b0;
                for (int j = 1; j < k; j++) if (ids[8*j +: 8] == b) clash = 1'b1;
            end while (clash);
            ids[8*k +: 8] = b;
        end
        return ids;
    endfunction

    task automatic drive_item(input logic cmd, input logic [7:0] src, input logic [1:0] tag,
                              input logic signed [31:0] val);
        if (!steady) begin
            while ($urandom_range(0, 99) < 8) begin
                i_valid <= 1'b0;
                @(posedge i_clk);
            end
        end
        i_valid       <= 1'b1;
        i_command     <= cmd;
        i_source_node <= src;
        i_msg_tag     <= tag;
        i_msg_value   <= val;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        last_ignored = sb.take_item(cmd, src, tag, val);
    endtask

    task automatic random_item();
        int r;
        int kind;
        r = $urandom_range(0, 99);
        kind = (r < 35) ? 0 : (r < 68) ? 1 : 2;
        if (r < 5)
            drive_item(CMD_START, 8'($urandom_range(0, 255)), 2'($urandom_range(0, 3)),
                       rand_value());
        else
            drive_item(CMD_MESSAGE, pick_source(kind, 1'b0), 2'($urandom_range(0, 3)),
                       rand_value());
    endtask

    task automatic write_reg(input t_cfg_idx idx, input logic [63:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
        sb.set_reg(idx, data);
    endtask

    // drop valid and wait until every predicted result has come back
    task automatic settle();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // result side: checks each accepted result, then picks the next ready
    initial begin : result_sink
        int stall_left;
        wave_result got;
        stall_left = 0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_valid && i_ready) begin
                got.send_valid = o_send_valid;
                got.dest       = o_dest_node;
                got.tag        = o_out_tag;
                got.value      = o_out_value;
                got.last       = o_last;
                got.finished   = o_finished;
                got.status     = o_status;
                sb.match_result(got);
            end
            if (hold_req) begin
                hold_req = 1'b0;
                stall_left = 250;
            end
            if (stall_left > 0) begin
                stall_left--;
                i_ready <= 1'b0;
            end else begin
                i_ready <= steady || ($urandom_range(0, 99) >= 8);
            end
        end
    end

    initial begin : stimulus
        bit root_role;
        bit close_by_count;
        int useful;
        logic [7:0] src;
        logic [63:0] ids;
        i_rst_n       = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_index   = CFG_IS_INITIATOR;
        i_cfg_data    = '0;
        i_valid       = 1'b0;
        i_command     = CMD_START;
        i_source_node = '0;
        i_msg_tag     = TAG_DOWN;
        i_msg_value   = '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        root_role = $urandom_range(0, 1);
        ids = make_ids();

        // message to an idle initiator is ignored
        write_reg(CFG_IS_INITIATOR, 64'd1);
        write_reg(CFG_NEIGHBOR_COUNT, 64'd0);
        write_reg(CFG_LOCAL_VALUE, 64'h7fffffff);
        drive_item(CMD_MESSAGE, 8'($urandom_range(0, 255)), TAG_END, 32'sd0);
        settle();
        write_reg(CFG_NEIGHBOR_COUNT, 64'd15);
        write_reg(CFG_NEIGHBOR_IDS, ids);

        if (root_role) begin
            drive_item(CMD_START, 8'h00, TAG_DOWN, 32'sd0);
            drive_item(CMD_START, 8'hff, TAG_END, '1);
        end else begin
            write_reg(CFG_IS_INITIATOR, 64'd0);
            write_reg(CFG_LOCAL_VALUE, 64'($urandom));
            drive_item(CMD_START, 8'h5a, TAG_DOWN, 32'sd0);
            // parent either a table entry or a stranger
            src = pick_source($urandom_range(0, 1) ? 1 : 2, 1'b0);
            drive_item(CMD_MESSAGE, src, 2'($urandom_range(0, 3)), {1'b0, {31{1'b1}}});
            drive_item(CMD_START, 8'h00, TAG_DOWN, 32'sd0);
        end

        // every tag counts as a report, duplicate and stranger reports
        foreach (tag_list[t]) begin
            src = pick_source(0, 1'b0);
            drive_item(CMD_MESSAGE, src, tag_list[t], (t == 0) ? {1'b0, {31{1'b1}}} :
                       (t == 1) ? 32'sd0 : (t == 2) ? -32'sd1 : 32'sd1);
        end
        drive_item(CMD_MESSAGE, src, TAG_UP, -32'sd5);
        drive_item(CMD_MESSAGE, pick_source(2, 1'b0), TAG_CALC, 32'sh7ffffffe);

        for (int seg = 0; seg < 4; seg++) begin
            steady = (seg == 1);
            if (seg == 2) hold_req = 1'b1;
            useful = 0;
            while (useful < 22 && sb.phase == PH_WAVE) begin
                random_item();
                if (!last_ignored) useful++;
            end
            steady = 1'b0;
            settle();
            case (seg)
                0: begin
                    write_reg(CFG_NEIGHBOR_COUNT, 64'($urandom_range(8, 15)));
                    write_reg(CFG_LOCAL_VALUE, 64'($urandom));
                end
                1: begin
                    // the role only matters before the wave starts
                    write_reg(CFG_IS_INITIATOR, 64'(!root_role));
                    write_reg(CFG_NEIGHBOR_IDS, {ids[55:0], ids[63:56]});
                end
                2: begin
                    write_reg(CFG_NEIGHBOR_COUNT, 64'd15);
                    write_reg(CFG_LOCAL_VALUE, 64'h80000000);
                end
                default: write_reg(CFG_NEIGHBOR_COUNT, 64'd8);
            endcase
        end

        close_by_count = $urandom_range(0, 1);
        if (close_by_count) begin
            // no neighbors left: the next report closes the wave
            write_reg(CFG_NEIGHBOR_COUNT, 64'd0);
            drive_item(CMD_MESSAGE, pick_source(2, 1'b1), TAG_UP, rand_value());
            settle();
            write_reg(CFG_NEIGHBOR_COUNT, 64'd8);
        end else begin
            while (sb.phase == PH_WAVE)
                drive_item(CMD_MESSAGE, pick_source(0, 1'b1),
                           ($urandom_range(0, 9) < 7) ? TAG_UP : 2'($urandom_range(0, 3)),
                           rand_value());
        end

        if (sb.phase == PH_REPORTED) begin
            drive_item(CMD_MESSAGE, pick_source(1, 1'b1), TAG_UP, rand_value());
            drive_item(CMD_START, 8'($urandom_range(0, 255)), TAG_DOWN, rand_value());
            drive_item(CMD_MESSAGE, sb.parent_id, TAG_END, {1'b1, 31'b0});
        end
        // finished node ignores everything
        drive_item(CMD_MESSAGE, 8'($urandom_range(0, 255)), TAG_END, rand_value());
        drive_item(CMD_START, 8'($urandom_range(0, 255)), TAG_DOWN, rand_value());

        settle();
        repeat (16) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end
endmodule
